[rtl/core/priority_run_queue_core_defines.svh]
// ----------------------------------------------------------------------------
// priority_run_queue_core_defines
// Assertion macros used by the run queue port checker (prq_checker).
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RUN_QUEUE_CORE_DEFINES_SVH
`define PRIORITY_RUN_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PRQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PRQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prq assertion failed");

`endif

[rtl/core/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg
// Types, constants and helpers of the priority run queue.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 3;
    localparam int SLICE_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [PRIO_W-1:0] PRIO_MIN = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd5;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_TIMESLICE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_TIMESLICE = 1'd1;

    localparam logic [CFG_W-1:0] BASE_TIMESLICE_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] EMPTY_TIMESLICE_RST = 16'd5000;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry ent;
    } t_cell_cmd;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] task_priority;
    } t_req;

    typedef struct packed {
        logic               preempt;
        logic               overflow;
        logic               found;
        logic [ID_W-1:0]    out_id;
        logic [PRIO_W-1:0]  out_priority;
        logic [SLICE_W-1:0] timeslice;
    } t_rsp;

    function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W-1:0] r;
        if (p < PRIO_MIN) begin
            r = PRIO_MIN;
        end else if (p > PRIO_MAX) begin
            r = PRIO_MAX;
        end else begin
            r = p;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/prq_if.sv]
// ----------------------------------------------------------------------------
// prq_if
// Valid/ready channels for requests and results of the run queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface prq_req_if import prq_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface prq_rsp_if import prq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/prq_cell.sv]
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted shift chain: holds, inserts, or shifts in a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_cell import prq_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_occupied,
    input  wire t_entry    i_left,
    input  wire logic      i_left_keep,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    // new task goes behind this slot
    assign o_keep  = i_occupied && (r_entry.prio <= i_cmd.ent.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_cmd.ent;
            end else begin
                n_entry = i_left;
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

[rtl/core/priority_run_queue_core.sv]
// ----------------------------------------------------------------------------
// priority_run_queue_core
// Stable priority run queue of task ids with per-priority timeslices.
// ----------------------------------------------------------------------------
// The queue is a row of QUEUE_DEPTH cells kept in service order, and an
// enqueue or dequeue updates every cell at once (insert by compare-and-shift,
// dequeue by shift toward the head). The result beat is registered and
// appears the cycle after the request is accepted; a new request is taken
// whenever the result register is empty or being drained, so the sustained
// rate is one beat per cycle. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_run_queue_core import prq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    prq_req_if.sink                   i_req,
    prq_rsp_if.source                 o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   n_occ;
    logic [CFG_W-1:0]   r_base;
    logic [CFG_W-1:0]   r_empty_slice;
    logic               r_out_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    t_cell_cmd          w_cmd;
    t_entry             w_entry [QUEUE_DEPTH];
    logic               w_keep  [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  w_dist;
    logic [18:0]        w_prod;
    logic [19:0]        w_sum;
    logic [SLICE_W-1:0] w_slice;

    assign w_full   = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign w_empty  = (r_occ == '0);
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept = i_req.valid && i_req.ready;

    assign w_cmd.enq      = w_accept && (i_req.payload.req_type == REQ_ENQ) && !w_full;
    assign w_cmd.deq      = w_accept && (i_req.payload.req_type == REQ_DEQ) && !w_empty;
    assign w_cmd.ent.id   = i_req.payload.task_id;
    assign w_cmd.ent.prio = clamp_prio(i_req.payload.task_priority);

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_keep;

        if (k == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_entry[k-1];
            assign w_left_keep = w_keep[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = w_entry[k];
        end else begin : g_mid
            assign w_right = w_entry[k+1];
        end

        prq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occupied  (OCC_W'(k) < r_occ),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_entry     (w_entry[k]),
            .o_keep      (w_keep[k])
        );
    end

    // base + floor(base * (5 - p) / 8), saturated
    assign w_dist  = PRIO_MAX - w_entry[0].prio;
    assign w_prod  = 19'(r_base) * 19'(w_dist);
    assign w_sum   = 20'(r_base) + 20'(w_prod[18:3]);
    assign w_slice = (w_sum[19:16] != '0) ? '1 : w_sum[15:0];

    always_comb begin
        n_occ = r_occ;
        if (w_cmd.enq) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (w_cmd.deq) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_comb begin
        n_rsp = '0;
        if (i_req.payload.req_type == REQ_ENQ) begin
            n_rsp.overflow = w_full;
            n_rsp.preempt  = w_empty;
        end else if (w_empty) begin
            n_rsp.timeslice = r_empty_slice;
        end else begin
            n_rsp.found        = 1'b1;
            n_rsp.out_id       = w_entry[0].id;
            n_rsp.out_priority = w_entry[0].prio;
            n_rsp.timeslice    = w_slice;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ         <= '0;
            r_out_valid   <= 1'b0;
            r_base        <= BASE_TIMESLICE_RST;
            r_empty_slice <= EMPTY_TIMESLICE_RST;
        end else begin
            r_occ <= n_occ;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_TIMESLICE:  r_base        <= i_cfg_wdata;
                    REG_EMPTY_TIMESLICE: r_empty_slice <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

endmodule

`default_nettype wire

[rtl/core/prq_checker.sv]
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks of the run queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_run_queue_core_defines.svh"

module prq_checker import prq_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire t_req i_req_payload,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp i_rsp_payload
);

    logic w_req_beat;
    logic w_deq_beat;
    logic w_rsp_stall;
    logic w_enq_flags;
    assign w_req_beat  = i_req_valid && i_req_ready;
    assign w_deq_beat  = w_req_beat && (i_req_payload.req_type == REQ_DEQ);
    assign w_rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign w_enq_flags = i_rsp_payload.preempt || i_rsp_payload.overflow;

    `PRQ_ASSERT_NEXT(a_beat_gives_result, i_clk, i_rst_n, w_req_beat, i_rsp_valid)

    `PRQ_ASSERT_NOW(a_stall_blocks_req, i_clk, i_rst_n, w_rsp_stall, !i_req_ready)

    `PRQ_ASSERT_NEXT(a_deq_no_enq_flags, i_clk, i_rst_n, w_deq_beat, !w_enq_flags)

    `PRQ_ASSERT_NEXT(a_rsp_holds, i_clk, i_rst_n, w_rsp_stall, i_rsp_valid && $stable(i_rsp_payload))

endmodule

bind priority_run_queue_core prq_checker u_prq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_payload (i_req.payload),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);

`default_nettype wire

[dv/prq_run_queue_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_run_queue_checker
// Predicts and checks every result beat of the priority run queue.
// ----------------------------------------------------------------------------
// Follows the register writes and every accepted request beat, keeps its own
// run list in service order, and compares each accepted result beat field by
// field with the oldest predicted result. Counts and reports mismatches.
// ----------------------------------------------------------------------------
module prq_run_queue_checker import prq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    prq_req_if                   i_req,
    prq_rsp_if                   i_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_results
);

    t_entry           run_list[$];
    t_rsp             owed_results[$];
    logic [CFG_W-1:0] base_slice  = BASE_TIMESLICE_RST;
    logic [CFG_W-1:0] empty_slice = EMPTY_TIMESLICE_RST;
    int               errs = 0;
    int               seen = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    // Updates the run list for one request and returns the result it causes.
    function automatic t_rsp apply_request(input t_req r);
        t_rsp              res;
        t_entry            ent;
        logic [PRIO_W-1:0] p;
        int                pos;
        int unsigned       b;
        int unsigned       d;
        int unsigned       ts;
        res = '0;
        if (r.req_type == REQ_ENQ) begin
            p = r.task_priority;
            if (p < PRIO_MIN) begin
                p = PRIO_MIN;
            end else if (p > PRIO_MAX) begin
                p = PRIO_MAX;
            end
            if (run_list.size() >= QUEUE_DEPTH) begin
                res.overflow = 1'b1;
            end else begin
                res.preempt = (run_list.size() == 0);
                pos = 0;
                while (pos < run_list.size() && run_list[pos].prio <= p) pos++;
                ent.id   = r.task_id;
                ent.prio = p;
                run_list.insert(pos, ent);
            end
        end else if (run_list.size() == 0) begin
            res.timeslice = empty_slice;
        end else begin
            ent = run_list.pop_front();
            res.found        = 1'b1;
            res.out_id       = ent.id;
            res.out_priority = ent.prio;
            b  = 32'(base_slice);
            d  = 32'(PRIO_MAX - ent.prio);
            ts = b + (b * d) / 8;
            res.timeslice = (ts > 32'hFFFF) ? 16'hFFFF : ts[SLICE_W-1:0];
        end
        return res;
    endfunction

    function automatic string rsp_text(input t_rsp r);
        return $sformatf("preempt=%0d overflow=%0d found=%0d id=%0d prio=%0d slice=%0d",
                         r.preempt, r.overflow, r.found, r.out_id, r.out_priority,
                         r.timeslice);
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            run_list.delete();
            owed_results.delete();
            base_slice  = BASE_TIMESLICE_RST;
            empty_slice = EMPTY_TIMESLICE_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_TIMESLICE:  base_slice  = i_cfg_wdata;
                    REG_EMPTY_TIMESLICE: empty_slice = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                owed_results.push_back(apply_request(i_req.payload));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                seen++;
                if (owed_results.size() == 0) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("[%0t] result beat with nothing outstanding: %s",
                                 $time, rsp_text(got));
                    end
                end else begin
                    want = owed_results.pop_front();
                    if (got.preempt !== want.preempt || got.overflow !== want.overflow ||
                        got.found !== want.found || got.out_id !== want.out_id ||
                        got.out_priority !== want.out_priority ||
                        got.timeslice !== want.timeslice) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("[%0t] result mismatch", $time);
                            $display("  expected %s", rsp_text(want));
                            $display("  actual   %s", rsp_text(got));
                        end
                    end
                end
            end
        end
        o_mismatches <= errs;
        o_pending    <= owed_results.size();
        o_results    <= seen;
    end

endmodule

[dv/tb_priority_run_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_run_queue_core
// Testbench of the priority run queue core.
// ----------------------------------------------------------------------------
// Runs a short directed sequence (empty dequeue, fill with every priority,
// overflow, partial drain), then fill, drain and mixed bursts with random ids
// and priorities under several timeslice settings, extremes included. Both
// channels stall at random. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_priority_run_queue_core;
    import prq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 160;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 steady = 1'b0;
    int                   mismatches;
    int                   pending;
    int                   results;
    int                   n_enq = 0;
    int                   n_deq = 0;
    int                   idle_cycles = 0;

    prq_req_if req_ch ();
    prq_rsp_if rsp_ch ();

    priority_run_queue_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    prq_run_queue_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio);
        int   gap;
        t_req r;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.req_type      = kind;
        r.task_id       = id;
        r.task_priority = prio;
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        if (kind == REQ_ENQ) n_enq++;
        else n_deq++;
    endtask

    // Holds the request side until every predicted result has come back.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Fill, drain and mixed bursts; some bursts use two adjacent priorities
    // to stress arrival order among equals.
    task automatic run_bursts(input int count);
        int                done_cnt;
        int                len;
        int                mode;
        int                pct;
        int                k;
        logic              narrow;
        logic [PRIO_W-1:0] lo;
        logic [PRIO_W-1:0] prio;
        done_cnt = 0;
        while (done_cnt < count) begin
            mode   = $urandom_range(0, 2);
            len    = $urandom_range(4, 24);
            steady = ($urandom_range(0, 4) == 0);
            narrow = ($urandom_range(0, 2) == 0);
            lo     = PRIO_W'($urandom_range(0, 6));
            pct    = (mode == 0) ? 90 : (mode == 1) ? 15 : 55;
            for (k = 0; k < len && done_cnt < count; k++) begin
                prio = narrow ? lo + PRIO_W'($urandom_range(0, 1))
                              : PRIO_W'($urandom_range(0, 7));
                send_request(($urandom_range(0, 99) < pct) ? REQ_ENQ : REQ_DEQ,
                             ID_W'($urandom_range(0, 65535)), prio);
                done_cnt++;
            end
        end
        steady = 1'b0;
    endtask

    // Result side: ready bursts with random stalls between them.
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(30, 120)) @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            gap = steady ? 0 : pick_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int               i;
        int               phase;
        logic [CFG_W-1:0] base;
        logic [CFG_W-1:0] empty;
        logic [ID_W-1:0]  id;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= REG_BASE_TIMESLICE;
        cfg_wdata      <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset timeslices
        send_request(REQ_DEQ, 16'h0000, 3'd0);
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            id = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i * 16'h0F0F);
            send_request(REQ_ENQ, id, 3'(i % 8));
        end
        send_request(REQ_ENQ, 16'hFFFF, 3'd7);
        for (i = 0; i < 8; i++) begin
            send_request(REQ_DEQ, 16'hFFFF, 3'd7);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin base = 16'd1;     empty = 16'd1;     end
                1: begin base = 16'hFFFF;  empty = 16'hFFFF;  end
                2: begin base = 16'd0;     empty = 16'd0;     end
                3: begin base = 16'd40000; empty = 16'd1;     end
                4: begin base = 16'd8191;  empty = 16'd65534; end
                default: begin
                    base  = CFG_W'($urandom_range(1, 40000));
                    empty = CFG_W'($urandom_range(1, 65535));
                end
            endcase
            wait_for_results();
            write_reg(REG_BASE_TIMESLICE, base);
            write_reg(REG_EMPTY_TIMESLICE, empty);
            run_bursts(PHASE_ITEMS);
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        $display("Run covered %0d requests (%0d enqueue, %0d dequeue) under %0d timeslice settings",
                 n_enq + n_deq, n_enq, n_deq, PHASES + 1);
        $display("%0d result beats compared, %0d mismatches", results, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[priority_run_queue_core.f]
+incdir+rtl/core
rtl/core/prq_pkg.sv
rtl/core/prq_if.sv
rtl/core/prq_cell.sv
rtl/core/priority_run_queue_core.sv
rtl/core/prq_checker.sv
dv/prq_run_queue_checker.sv
dv/tb_priority_run_queue_core.sv
